// ----- src/pidl_pkg.sv -----
// Package for the positional insert/delete list.
// Holds sizes, operation and status codes, and the control bundle sent to the cells.
// No dependencies.
package pidl_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = 5;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_DUMP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_BAD_POS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_APPEND,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    // broadcast to every cell in the row
    typedef struct packed {
        cell_op_t                  op;
        logic [POS_W-1:0]          pos;
        logic [CNT_W-1:0]          count;
        logic signed [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

// ----- src/pidl_cell.sv -----
// One storage cell of the list row.
// Holds one entry and picks its next value from itself, the new value, a neighbor or the head.
// Depends on pidl_pkg.
module pidl_cell
(
    input  logic                                clk,
    input  pidl_pkg::cell_ctrl_t                ctrl,
    input  logic [pidl_pkg::IDX_W-1:0]          idx,
    input  logic signed [pidl_pkg::DATA_W-1:0]  left,
    input  logic signed [pidl_pkg::DATA_W-1:0]  right,
    input  logic signed [pidl_pkg::DATA_W-1:0]  head,
    output logic signed [pidl_pkg::DATA_W-1:0]  q
);

    logic signed [pidl_pkg::DATA_W-1:0] q_reg;
    logic signed [pidl_pkg::DATA_W-1:0] q_next;
    logic [pidl_pkg::CNT_W-1:0]         my_idx;
    logic [pidl_pkg::CNT_W-1:0]         my_idx_p1;

    assign my_idx    = pidl_pkg::CNT_W'(idx);
    assign my_idx_p1 = my_idx + pidl_pkg::CNT_W'(1);

    always_comb
    begin
        q_next = q_reg;
        case (ctrl.op)
            pidl_pkg::OP_APPEND:
            begin
                if (my_idx == ctrl.count)
                    q_next = ctrl.value;
            end
            pidl_pkg::OP_INSERT:
            begin
                if (my_idx == ctrl.pos)
                    q_next = ctrl.value;
                else if (my_idx > ctrl.pos && my_idx <= ctrl.count)
                    q_next = left;
            end
            pidl_pkg::OP_DELETE:
            begin
                if (my_idx >= ctrl.pos)
                    q_next = right;
            end
            pidl_pkg::OP_ROTATE:
            begin
                // rotate the used part by one toward the head
                if (my_idx_p1 < ctrl.count)
                    q_next = right;
                else if (my_idx_p1 == ctrl.count)
                    q_next = head;
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ----- src/positional_insert_delete_list_core.sv -----
// Top level of the positional insert/delete list.
// Row of pidl_cell instances, operation decode, dump sequencer and result register.
// Depends on pidl_pkg and pidl_cell.
//
// Usage:
//   s_* carries one operation per transfer (append, insert, delete, dump).
//   m_* carries the results; tlast marks the final result of an operation.
//   cfg_* writes the capacity limit; always ready, write only while idle.
// Operation flow:
//   Append, insert and delete update every cell at once and give one result
//   in the cycle after the transfer, so one such operation is taken per cycle
//   while the receiver keeps up.
//   A dump of N > 0 entries gives N results, one per cycle while the receiver keeps up;
//   the row rotates by one cell per result and is back in order after the last. No new
//   operation is taken until the last dump result is in the result register.
// Reset:
//   rst_n clears the count, sets the capacity limit to 16 and empties the
//   result register; cell contents are left as they are.
// Stall:
//   While a result is held and m_tready is low, the result register holds and s_tready drops.
module positional_insert_delete_list_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pidl_pkg::CAP_W-1:0]            cfg_data,    // capacity_limit
    // operations in
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [pidl_pkg::IN_TDATA_W-1:0]       s_tdata,     // mode[1:0] position[6:2] value[38:7]
    // results out
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pidl_pkg::OUT_TDATA_W-1:0]      m_tdata,     // status[1:0] count[6:2] is_empty[7] is_full[8] item[40:9]
    output logic                                  m_tuser,     // item_valid
    output logic                                  m_tlast
);

    localparam int D = pidl_pkg::DEPTH;

    pidl_pkg::state_t                    state_reg;
    pidl_pkg::state_t                    state_next;
    logic [pidl_pkg::CNT_W-1:0]          count_reg;
    logic [pidl_pkg::CNT_W-1:0]          count_next;
    logic [pidl_pkg::CNT_W-1:0]          remain_reg;
    logic [pidl_pkg::CNT_W-1:0]          remain_next;
    logic [pidl_pkg::CAP_W-1:0]          cap_reg;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    pidl_pkg::status_t                   out_status_reg;
    pidl_pkg::status_t                   out_status_next;
    logic [pidl_pkg::CNT_W-1:0]          out_count_reg;
    logic                                out_empty_reg;
    logic                                out_full_reg;
    logic                                out_ivalid_reg;
    logic                                out_ivalid_next;
    logic signed [pidl_pkg::DATA_W-1:0]  out_item_reg;
    logic signed [pidl_pkg::DATA_W-1:0]  out_item_next;
    logic                                out_last_reg;
    logic                                out_last_next;
    logic                                out_load;

    logic                                in_fire;
    logic                                out_free;
    pidl_pkg::mode_t                     in_mode;
    logic [pidl_pkg::POS_W-1:0]          in_pos;
    logic signed [pidl_pkg::DATA_W-1:0]  in_value;
    logic [pidl_pkg::CNT_W-1:0]          eff_cap;
    logic                                full_now;

    pidl_pkg::cell_ctrl_t                ctrl;
    pidl_pkg::cell_op_t                  cell_op;
    logic signed [pidl_pkg::DATA_W-1:0]  cell_q [D];

    assign in_mode  = pidl_pkg::mode_t'(s_tdata[1:0]);
    assign in_pos   = s_tdata[6:2];
    assign in_value = s_tdata[38:7];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == pidl_pkg::ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign eff_cap  = (cap_reg > pidl_pkg::DEPTH_CNT) ? pidl_pkg::DEPTH_CNT : cap_reg;
    assign full_now = count_reg >= eff_cap;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pidl_pkg::ST_IDLE:
            begin
                if (in_fire && in_mode == pidl_pkg::MODE_DUMP &&
                    count_reg > pidl_pkg::CNT_W'(1))
                    state_next = pidl_pkg::ST_DUMP;
            end
            pidl_pkg::ST_DUMP:
            begin
                if (out_free && remain_reg == pidl_pkg::CNT_W'(1))
                    state_next = pidl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pidl_pkg::ST_IDLE;
            end
        endcase
    end

    // decode, cell control and result fields
    always_comb
    begin
        cell_op         = pidl_pkg::OP_NONE;
        count_next      = count_reg;
        remain_next     = remain_reg;
        out_load        = 1'b0;
        out_status_next = pidl_pkg::STAT_OK;
        out_ivalid_next = 1'b0;
        out_item_next   = '0;
        out_last_next   = 1'b1;
        case (state_reg)
            pidl_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_load = 1'b1;
                    case (in_mode)
                        pidl_pkg::MODE_APPEND:
                        begin
                            if (full_now)
                                out_status_next = pidl_pkg::STAT_FULL;
                            else
                            begin
                                cell_op    = pidl_pkg::OP_APPEND;
                                count_next = count_reg + pidl_pkg::CNT_W'(1);
                            end
                        end
                        pidl_pkg::MODE_INSERT:
                        begin
                            if (full_now)
                                out_status_next = pidl_pkg::STAT_FULL;
                            else if (in_pos > count_reg)
                                out_status_next = pidl_pkg::STAT_BAD_POS;
                            else
                            begin
                                cell_op    = pidl_pkg::OP_INSERT;
                                count_next = count_reg + pidl_pkg::CNT_W'(1);
                            end
                        end
                        pidl_pkg::MODE_DELETE:
                        begin
                            if (count_reg == '0)
                                out_status_next = pidl_pkg::STAT_EMPTY;
                            else if (in_pos >= count_reg)
                                out_status_next = pidl_pkg::STAT_BAD_POS;
                            else
                            begin
                                cell_op    = pidl_pkg::OP_DELETE;
                                count_next = count_reg - pidl_pkg::CNT_W'(1);
                            end
                        end
                        pidl_pkg::MODE_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                cell_op         = pidl_pkg::OP_ROTATE;
                                out_ivalid_next = 1'b1;
                                out_item_next   = cell_q[0];
                                out_last_next   = (count_reg == pidl_pkg::CNT_W'(1));
                                remain_next     = count_reg - pidl_pkg::CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            out_status_next = pidl_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            pidl_pkg::ST_DUMP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    cell_op         = pidl_pkg::OP_ROTATE;
                    out_ivalid_next = 1'b1;
                    out_item_next   = cell_q[0];
                    out_last_next   = (remain_reg == pidl_pkg::CNT_W'(1));
                    remain_next     = remain_reg - pidl_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                cell_op = pidl_pkg::OP_NONE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && !m_tready);

    assign ctrl.op    = cell_op;
    assign ctrl.pos   = in_pos;
    assign ctrl.count = count_reg;
    assign ctrl.value = in_value;

    genvar gi;
    generate
        for (gi = 0; gi < D; gi++)
        begin : g_cell
            logic signed [pidl_pkg::DATA_W-1:0] left_d;
            logic signed [pidl_pkg::DATA_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[gi-1];
            end
            if (gi == D - 1)
            begin : g_last
                assign right_d = cell_q[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[gi+1];
            end
            pidl_cell u_cell
            (
                .clk   (clk),
                .ctrl  (ctrl),
                .idx   (pidl_pkg::IDX_W'(gi)),
                .left  (left_d),
                .right (right_d),
                .head  (cell_q[0]),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidl_pkg::ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            cap_reg       <= pidl_pkg::CAP_W'(16);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    // result payload, loaded on each new result
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_count_reg  <= count_next;
            out_empty_reg  <= (count_next == '0);
            out_full_reg   <= (count_next >= eff_cap);
            out_ivalid_reg <= out_ivalid_next;
            out_item_reg   <= out_item_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_item_reg, out_full_reg, out_empty_reg,
                       out_count_reg, out_status_reg};
    assign m_tuser  = out_ivalid_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/pidl_chk.sv -----
// Port-level checker for the positional insert/delete list, with its bind.
// Watches only the top level's ports.
// Depends on pidl_pkg and positional_insert_delete_list_core.
module pidl_chk
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tready,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [pidl_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 m_tuser,
    input  logic                                 m_tlast
);

    // a stalled result stays presented
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // no item value without item_valid
    a_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[40:9] == 32'd0)
        else $error("item nonzero without item_valid");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7] == (m_tdata[6:2] == 5'd0))
        else $error("is_empty disagrees with count");

    // an error result is a single, final result
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != pidl_pkg::STAT_OK |-> m_tlast && !m_tuser)
        else $error("error result not final");

    // no new operation while a dump is still running
    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken during dump");

endmodule

bind positional_insert_delete_list_core pidl_chk u_pidl_chk (.*);

// ----- test/tb_positional_insert_delete_list_core.sv -----
// Self-checking testbench for positional_insert_delete_list_core.
// Runs a directed table and then randomized list traffic, checking every result against a
// built-in list predictor. Depends on pidl_pkg and the core RTL.
module tb_positional_insert_delete_list_core;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int NUM_PHASES  = 9;

    typedef struct {
        pidl_pkg::status_t                  status;
        logic [pidl_pkg::CNT_W-1:0]         count;
        logic                               is_empty;
        logic                               is_full;
        logic                               item_valid;
        logic signed [pidl_pkg::DATA_W-1:0] item;
        logic                               last;
    } list_result_t;

    typedef struct {
        bit                          is_cfg;
        logic [pidl_pkg::CAP_W-1:0]  cap;
        pidl_pkg::mode_t             mode;
        logic [pidl_pkg::POS_W-1:0]  pos;
        logic [pidl_pkg::DATA_W-1:0] val;
        bit                          typed;
        pidl_pkg::status_t           st;
        logic [pidl_pkg::CNT_W-1:0]  cnt;
    } plan_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [pidl_pkg::CAP_W-1:0]       cfg_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [pidl_pkg::IN_TDATA_W-1:0]  s_tdata;   // mode[1:0] position[6:2] value[38:7]
    logic                             m_tvalid;
    logic                             m_tready;
    // status[1:0] count[6:2] is_empty[7] is_full[8] item[40:9]
    logic [pidl_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tuser;   // item_valid
    logic                             m_tlast;

    // predicted list contents and settings
    logic signed [pidl_pkg::DATA_W-1:0] shadow_list [pidl_pkg::DEPTH];
    int                                 shadow_len;
    int                                 shadow_cap;
    list_result_t                       expected_results [$];

    int  phase_cap [NUM_PHASES] = '{31, 3, 16, 1, 0, 9, 16, 24, 5};
    int  phase_len [NUM_PHASES] = '{70, 40, 80, 40, 20, 50, 80, 50, 30};

    int  fail_count;
    int  results_checked;
    int  cap_writes;
    int  cycles;
    int  ops_seen [4];
    int  status_seen [4];
    bit  tx_steady;
    bit  rx_steady;
    bit  long_hold_req;

    positional_insert_delete_list_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("positional_insert_delete_list_core test failed");
            $finish;
        end
    end

    function automatic bit shadow_full();
        return shadow_len >= ((shadow_cap > pidl_pkg::DEPTH) ? pidl_pkg::DEPTH : shadow_cap);
    endfunction

    function automatic void queue_result(pidl_pkg::status_t st, logic iv,
                                         logic signed [pidl_pkg::DATA_W-1:0] it, logic lst);
        list_result_t r;
        r.status     = st;
        r.count      = pidl_pkg::CNT_W'(shadow_len);
        r.is_empty   = (shadow_len == 0);
        r.is_full    = shadow_full();
        r.item_valid = iv;
        r.item       = it;
        r.last       = lst;
        expected_results.push_back(r);
    endfunction

    // Update the predicted list for one operation and queue its results.
    function automatic void apply_op(pidl_pkg::mode_t m, logic [pidl_pkg::POS_W-1:0] p,
                                     logic signed [pidl_pkg::DATA_W-1:0] v);
        int                i;
        pidl_pkg::status_t st;
        st = pidl_pkg::STAT_OK;
        ops_seen[int'(m)]++;
        case (m)
            pidl_pkg::MODE_DUMP:
            begin
                if (shadow_len == 0)
                    queue_result(pidl_pkg::STAT_OK, 1'b0, '0, 1'b1);
                else
                    for (i = 0; i < shadow_len; i++)
                        queue_result(pidl_pkg::STAT_OK, 1'b1, shadow_list[i],
                                     i == shadow_len - 1);
            end
            pidl_pkg::MODE_APPEND:
            begin
                if (shadow_full())
                    st = pidl_pkg::STAT_FULL;
                else
                begin
                    shadow_list[shadow_len] = v;
                    shadow_len++;
                end
            end
            pidl_pkg::MODE_INSERT:
            begin
                // full wins over a bad position
                if (shadow_full())
                    st = pidl_pkg::STAT_FULL;
                else if (p > shadow_len)
                    st = pidl_pkg::STAT_BAD_POS;
                else
                begin
                    for (i = shadow_len; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = v;
                    shadow_len++;
                end
            end
            default:
            begin
                if (shadow_len == 0)
                    st = pidl_pkg::STAT_EMPTY;
                else if (p >= shadow_len)
                    st = pidl_pkg::STAT_BAD_POS;
                else
                begin
                    for (i = p; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
        endcase
        if (m != pidl_pkg::MODE_DUMP)
        begin
            status_seen[int'(st)]++;
            queue_result(st, 1'b0, '0, 1'b1);
        end
    endfunction

    function automatic void check_field(string name, logic [pidl_pkg::DATA_W-1:0] want,
                                        logic [pidl_pkg::DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: tdata %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, m_tdata[1:0]);
                check_field("count", want.count, m_tdata[6:2]);
                check_field("is_empty", want.is_empty, m_tdata[7]);
                check_field("is_full", want.is_full, m_tdata[8]);
                check_field("item", want.item, m_tdata[40:9]);
                check_field("item_valid", want.item_valid, m_tuser);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // receiver: random stalls, quiet stretches, and one long hold-off on request
    initial
    begin
        int gap_left;
        int hold_left;
        m_tready  = 1'b0;
        gap_left  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                m_tready <= 1'b0;
                gap_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_steady && $urandom_range(3) == 0)
                    gap_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
            end
        end
    end

    function automatic plan_row_t step(pidl_pkg::mode_t m, logic [pidl_pkg::POS_W-1:0] p,
                                       logic [pidl_pkg::DATA_W-1:0] v, bit typed,
                                       pidl_pkg::status_t st, logic [pidl_pkg::CNT_W-1:0] cnt);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.cap    = '0;
        r.mode   = m;
        r.pos    = p;
        r.val    = v;
        r.typed  = typed;
        r.st     = st;
        r.cnt    = cnt;
        return r;
    endfunction

    function automatic plan_row_t cap_row(logic [pidl_pkg::CAP_W-1:0] cap);
        plan_row_t r;
        r        = step(pidl_pkg::MODE_DUMP, '0, '0, 1'b0, pidl_pkg::STAT_OK, '0);
        r.is_cfg = 1'b1;
        r.cap    = cap;
        return r;
    endfunction

    function automatic logic signed [pidl_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [pidl_pkg::POS_W-1:0] pick_pos(pidl_pkg::mode_t m);
        if ($urandom_range(4) == 0)
            return pidl_pkg::POS_W'($urandom_range(31));
        if (m == pidl_pkg::MODE_INSERT)
            return pidl_pkg::POS_W'($urandom_range(shadow_len));
        return (shadow_len == 0) ? '0 : pidl_pkg::POS_W'($urandom_range(shadow_len - 1));
    endfunction

    function automatic pidl_pkg::mode_t pick_mode(bit growing);
        int r;
        r = $urandom_range(99);
        if (growing)
            return (r < 40) ? pidl_pkg::MODE_APPEND : (r < 70) ? pidl_pkg::MODE_INSERT :
                   (r < 85) ? pidl_pkg::MODE_DELETE : pidl_pkg::MODE_DUMP;
        return (r < 15) ? pidl_pkg::MODE_APPEND : (r < 30) ? pidl_pkg::MODE_INSERT :
               (r < 80) ? pidl_pkg::MODE_DELETE : pidl_pkg::MODE_DUMP;
    endfunction

    // Offer one operation and hold it until the transfer; typed rows pin status and count.
    task automatic send_op(pidl_pkg::mode_t m, logic [pidl_pkg::POS_W-1:0] p,
                           logic signed [pidl_pkg::DATA_W-1:0] v, bit typed,
                           pidl_pkg::status_t st, logic [pidl_pkg::CNT_W-1:0] cnt);
        list_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, v, p, m};
        do @(posedge clk); while (!s_tready);
        apply_op(m, p, v);
        if (typed)
        begin
            r        = expected_results.pop_back();
            r.status = st;
            r.count  = cnt;
            expected_results.push_back(r);
        end
    endtask

    task automatic tx_gap();
        int len;
        if (!tx_steady && $urandom_range(2) == 0)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected result has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_cap(logic [pidl_pkg::CAP_W-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        shadow_cap = cap;
        cap_writes++;
    endtask

    initial
    begin
        plan_row_t       plan [$];
        pidl_pkg::mode_t m;
        int              ph;
        int              k;
        int              half;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        long_hold_req = 1'b0;
        shadow_len    = 0;
        shadow_cap    = 16;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, bad positions, extremes, full before position, capacity zero and
        // capacity dropped below the count, then saturation above the depth
        plan.push_back(step(pidl_pkg::MODE_DUMP,   5'd0,  32'h0,         1,
                            pidl_pkg::STAT_OK,      5'd0));
        plan.push_back(step(pidl_pkg::MODE_DELETE, 5'd0,  32'h0,         1,
                            pidl_pkg::STAT_EMPTY,   5'd0));
        plan.push_back(step(pidl_pkg::MODE_INSERT, 5'd1,  32'h5,         1,
                            pidl_pkg::STAT_BAD_POS, 5'd0));
        plan.push_back(step(pidl_pkg::MODE_APPEND, 5'd0,  32'h7FFF_FFFF, 1,
                            pidl_pkg::STAT_OK,      5'd1));
        plan.push_back(step(pidl_pkg::MODE_APPEND, 5'd31, 32'h8000_0000, 1,
                            pidl_pkg::STAT_OK,      5'd2));
        plan.push_back(step(pidl_pkg::MODE_INSERT, 5'd0,  32'hFFFF_FFFF, 1,
                            pidl_pkg::STAT_OK,      5'd3));
        plan.push_back(step(pidl_pkg::MODE_INSERT, 5'd3,  32'h0,         1,
                            pidl_pkg::STAT_OK,      5'd4));
        plan.push_back(step(pidl_pkg::MODE_INSERT, 5'd2,  32'h5555_5555, 0,
                            pidl_pkg::STAT_OK,      5'd0));
        plan.push_back(step(pidl_pkg::MODE_INSERT, 5'd31, 32'h1,         1,
                            pidl_pkg::STAT_BAD_POS, 5'd5));
        plan.push_back(step(pidl_pkg::MODE_DELETE, 5'd5,  32'h0,         1,
                            pidl_pkg::STAT_BAD_POS, 5'd5));
        plan.push_back(step(pidl_pkg::MODE_DELETE, 5'd31, 32'h0,         1,
                            pidl_pkg::STAT_BAD_POS, 5'd5));
        plan.push_back(step(pidl_pkg::MODE_DELETE, 5'd0,  32'h0,         0,
                            pidl_pkg::STAT_OK,      5'd0));
        plan.push_back(step(pidl_pkg::MODE_DELETE, 5'd3,  32'h0,         0,
                            pidl_pkg::STAT_OK,      5'd0));
        plan.push_back(step(pidl_pkg::MODE_DUMP,   5'd0,  32'h0,         0,
                            pidl_pkg::STAT_OK,      5'd0));
        plan.push_back(cap_row(5'd0));
        plan.push_back(step(pidl_pkg::MODE_APPEND, 5'd0,  32'hAAAA_AAAA, 1,
                            pidl_pkg::STAT_FULL,    5'd3));
        plan.push_back(step(pidl_pkg::MODE_INSERT, 5'd31, 32'h1234_5678, 1,
                            pidl_pkg::STAT_FULL,    5'd3));
        plan.push_back(step(pidl_pkg::MODE_DELETE, 5'd0,  32'h0,         0,
                            pidl_pkg::STAT_OK,      5'd0));
        plan.push_back(step(pidl_pkg::MODE_DUMP,   5'd0,  32'h0,         0,
                            pidl_pkg::STAT_OK,      5'd0));
        plan.push_back(cap_row(5'd2));
        plan.push_back(step(pidl_pkg::MODE_INSERT, 5'd0,  32'h0F0F_0F0F, 1,
                            pidl_pkg::STAT_FULL,    5'd2));
        plan.push_back(step(pidl_pkg::MODE_DELETE, 5'd1,  32'h0,         0,
                            pidl_pkg::STAT_OK,      5'd0));
        plan.push_back(step(pidl_pkg::MODE_APPEND, 5'd0,  32'h1234_5678, 0,
                            pidl_pkg::STAT_OK,      5'd0));
        plan.push_back(cap_row(5'd31));
        plan.push_back(step(pidl_pkg::MODE_INSERT, 5'd2,  32'hDEAD_0001, 1,
                            pidl_pkg::STAT_OK,      5'd3));
        plan.push_back(step(pidl_pkg::MODE_DUMP,   5'd0,  32'h0,         0,
                            pidl_pkg::STAT_OK,      5'd0));

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_cap(plan[i].cap);
            else
            begin
                send_op(plan[i].mode, plan[i].pos, plan[i].val, plan[i].typed,
                        plan[i].st, plan[i].cnt);
                tx_gap();
            end
        end

        // each phase grows the list for its first half and shrinks it for the second
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_cap(pidl_pkg::CAP_W'(phase_cap[ph]));
            tx_steady = (ph % 3 == 1) || (ph == 2);
            rx_steady = (ph % 3 == 2) && (ph != 2);
            // hold the receiver off while the sender keeps pushing
            if (ph == 2)
                long_hold_req = 1'b1;
            half = phase_len[ph] / 2;
            for (k = 0; k < phase_len[ph]; k++)
            begin
                if (k == half && ph % 2 == 1)
                    drain();
                m = pick_mode(k < half);
                send_op(m, pick_pos(m), pick_value(), 1'b0, pidl_pkg::STAT_OK, '0);
                tx_gap();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("checked %0d results from %0d appends, %0d inserts, %0d deletes, %0d dumps",
                 results_checked, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3]);
        $display("%0d capacity writes; statuses ok %0d, full %0d, empty %0d, bad position %0d",
                 cap_writes, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0)
            $display("positional_insert_delete_list_core test passed");
        else
            $display("positional_insert_delete_list_core test failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/pidl_pkg.sv
src/pidl_cell.sv
src/positional_insert_delete_list_core.sv
src/pidl_chk.sv
test/tb_positional_insert_delete_list_core.sv
